@@ rtl/oom_pkg.sv @@
`timescale 1ns / 1ps
// Package for the octree occupancy map unit.
// Holds sizes, codes and the command and status types; depends on nothing.
package oom_pkg;

	localparam int NODE_POOL   = 4096;
	localparam int NODE_W      = $clog2(NODE_POOL);
	localparam int NU_W        = NODE_W + 1;
	localparam int DEPTH_LIMIT = 16;
	localparam int LVL_W       = 5;
	localparam int COORD_W     = 32;
	localparam int CTR_W       = COORD_W + 2;
	localparam int HALF_W      = 30;
	localparam int OCC_W       = 2;
	localparam int STAT_W      = 2;
	localparam int SLOTS       = 8;
	localparam int OCT_W       = 3;
	localparam int ROW_W       = SLOTS * NODE_W + OCC_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [HALF_W-1:0] HALF_RESET  = HALF_W'(16777216);
	localparam logic [LVL_W-1:0]  DEPTH_RESET = LVL_W'(8);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [OCC_W-1:0] OCC_UNKNOWN  = 2'd0;
	localparam logic [OCC_W-1:0] OCC_FREE     = 2'd1;
	localparam logic [OCC_W-1:0] OCC_OCCUPIED = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd4;

	typedef struct packed {
		logic                      operation;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      mark_occupied;
	} item_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic bound;
		logic walk;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic outside;
		logic done;
		logic alloc;
		logic full;
	} stat_t;

endpackage

@@ rtl/oom_if.sv @@
`timescale 1ns / 1ps
// Item and result channel interfaces of the octree occupancy map unit.
// Depends on oom_pkg for field widths.
interface oom_item_if;
	import oom_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic                      mark_occupied;

	modport source (
		output valid, operation, point_x, point_y, point_z, mark_occupied,
		input  ready
	);
	modport sink (
		input  valid, operation, point_x, point_y, point_z, mark_occupied,
		output ready
	);
endinterface

interface oom_result_if;
	import oom_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [OCC_W-1:0]  occupancy;

	modport source (
		output valid, status, occupancy,
		input  ready
	);
	modport sink (
		input  valid, status, occupancy,
		output ready
	);
endinterface

@@ rtl/oom_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; no package needed.
module oom_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/oom_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the octree occupancy map unit: clearing pass, descent and result handoff.
// Depends on oom_pkg for the command and status types.
module oom_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  oom_pkg::stat_t stat,
	output oom_pkg::cmd_t  cmd
);
	import oom_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_BOUND  = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_BOUND;
				end
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d   = stat.outside ? S_RESULT : S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/oom_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the octree occupancy map unit: configuration, bounds test,
// octant walk over the node row memory and result registers. Uses oom_pkg and oom_ram.
module oom_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [oom_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oom_pkg::CFG_DATA_W-1:0] cfg_data,
	input  oom_pkg::item_t                 item,
	input  oom_pkg::cmd_t                  cmd,
	output oom_pkg::stat_t                 stat,
	output logic [oom_pkg::STAT_W-1:0]     out_status,
	output logic [oom_pkg::OCC_W-1:0]      out_occupancy
);
	import oom_pkg::*;

	logic signed [COORD_W-1:0] cfg_cx_q;
	logic signed [COORD_W-1:0] cfg_cy_q;
	logic signed [COORD_W-1:0] cfg_cz_q;
	logic [HALF_W-1:0]         cfg_half_q;
	logic [LVL_W-1:0]          cfg_depth_q;

	logic                      op_q;
	logic                      occ_q;
	logic signed [COORD_W-1:0] px_q;
	logic signed [COORD_W-1:0] py_q;
	logic signed [COORD_W-1:0] pz_q;
	logic signed [CTR_W-1:0]   cx_q;
	logic signed [CTR_W-1:0]   cy_q;
	logic signed [CTR_W-1:0]   cz_q;
	logic [HALF_W-1:0]         half_q;
	logic [LVL_W-1:0]          depth_q;
	logic [LVL_W-1:0]          lvl_q;
	logic [NODE_W-1:0]         node_q;
	logic [NU_W-1:0]           nodes_used_q;
	logic [NODE_W-1:0]         clr_q;
	logic [STAT_W-1:0]         res_status_q;
	logic [OCC_W-1:0]          res_occ_q;
	logic [STAT_W-1:0]         out_status_q;
	logic [OCC_W-1:0]          out_occ_q;

	logic signed [CTR_W-1:0] px_e;
	logic signed [CTR_W-1:0] py_e;
	logic signed [CTR_W-1:0] pz_e;
	logic signed [CTR_W-1:0] h_e;
	logic signed [CTR_W-1:0] q_e;
	logic signed [CTR_W-1:0] dx;
	logic signed [CTR_W-1:0] dy;
	logic signed [CTR_W-1:0] dz;
	logic [HALF_W-1:0]       q;
	logic                    outside;
	logic [OCT_W-1:0]        oct;
	logic [ROW_W-1:0]        row;
	logic [ROW_W-1:0]        wrow;
	logic [OCC_W-1:0]        nstate;
	logic [NODE_W-1:0]       child;
	logic [NODE_W-1:0]       next_node;
	logic [OCC_W-1:0]        new_state;
	logic                    at_leaf;
	logic                    miss;
	logic                    is_query;
	logic                    full;
	logic                    walk_done;
	logic                    advance;
	logic                    alloc;
	logic                    leaf_write;
	logic                    capture;
	logic [STAT_W-1:0]       res_status_d;
	logic [OCC_W-1:0]        res_occ_d;
	logic                    ram_we;
	logic [NODE_W-1:0]       ram_waddr;
	logic [ROW_W-1:0]        ram_wdata;
	logic [NODE_W-1:0]       ram_raddr;

	// Bounds test against the root cube, bounds included.
	assign px_e = CTR_W'(px_q);
	assign py_e = CTR_W'(py_q);
	assign pz_e = CTR_W'(pz_q);
	assign h_e  = $signed(CTR_W'(half_q));
	assign dx   = px_e - cx_q;
	assign dy   = py_e - cy_q;
	assign dz   = pz_e - cz_q;
	assign outside = (dx > h_e) || (dx < -h_e) || (dy > h_e) || (dy < -h_e) ||
		(dz > h_e) || (dz < -h_e);

	// One level of the descent.
	assign q         = half_q >> 1;
	assign q_e       = $signed(CTR_W'(q));
	assign oct       = {pz_e > cz_q, py_e > cy_q, px_e > cx_q};
	assign nstate    = row[ROW_W-1 -: OCC_W];
	assign child     = row[oct*NODE_W +: NODE_W];
	assign at_leaf   = (lvl_q == depth_q);
	assign miss      = (child == '0);
	assign is_query  = (op_q == OP_QUERY);
	assign full      = (nodes_used_q == NU_W'(NODE_POOL));
	assign new_state = occ_q ? OCC_OCCUPIED : OCC_FREE;
	assign walk_done = at_leaf || (miss && (is_query || full));
	assign advance   = cmd.walk && !walk_done;
	assign alloc     = advance && miss;
	assign leaf_write = cmd.walk && at_leaf && !is_query;
	assign next_node = miss ? nodes_used_q[NODE_W-1:0] : child;

	always_comb begin
		wrow = row;
		if (at_leaf) begin
			wrow[ROW_W-1 -: OCC_W] = new_state;
		end else begin
			wrow[oct*NODE_W +: NODE_W] = nodes_used_q[NODE_W-1:0];
		end
	end

	always_comb begin
		res_status_d = STAT_OK;
		res_occ_d    = OCC_UNKNOWN;
		if (cmd.bound) begin
			res_status_d = STAT_OUTSIDE;
		end else if (at_leaf) begin
			res_occ_d = is_query ? nstate : new_state;
		end else if (is_query) begin
			res_occ_d = nstate;
		end else begin
			res_status_d = STAT_FULL;
		end
	end

	assign capture = (cmd.bound && outside) || (cmd.walk && walk_done);

	assign ram_we    = cmd.clear || alloc || leaf_write;
	assign ram_waddr = cmd.clear ? clr_q : node_q;
	assign ram_wdata = cmd.clear ? '0 : wrow;
	assign ram_raddr = cmd.walk ? next_node : '0;

	oom_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NODE_POOL)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(row)
	);

	assign stat.clear_last = (clr_q == NODE_W'(NODE_POOL - 1));
	assign stat.outside    = outside;
	assign stat.done       = walk_done;
	assign stat.alloc      = alloc;
	assign stat.full       = full;

	assign out_status    = out_status_q;
	assign out_occupancy = out_occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_cx_q     <= '0;
			cfg_cy_q     <= '0;
			cfg_cz_q     <= '0;
			cfg_half_q   <= HALF_RESET;
			cfg_depth_q  <= DEPTH_RESET;
			nodes_used_q <= NU_W'(1);
			clr_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CENTER_X:  cfg_cx_q    <= $signed(cfg_data);
					REG_CENTER_Y:  cfg_cy_q    <= $signed(cfg_data);
					REG_CENTER_Z:  cfg_cz_q    <= $signed(cfg_data);
					REG_HALF_SIZE: cfg_half_q  <= cfg_data[HALF_W-1:0];
					REG_MAX_DEPTH: cfg_depth_q <= cfg_data[LVL_W-1:0];
					default: begin
					end
				endcase
			end
			if (alloc) begin
				nodes_used_q <= nodes_used_q + NU_W'(1);
			end
			if (cmd.clear) begin
				clr_q <= clr_q + NODE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= item.operation;
			occ_q   <= item.mark_occupied;
			px_q    <= item.point_x;
			py_q    <= item.point_y;
			pz_q    <= item.point_z;
			cx_q    <= CTR_W'(cfg_cx_q);
			cy_q    <= CTR_W'(cfg_cy_q);
			cz_q    <= CTR_W'(cfg_cz_q);
			half_q  <= cfg_half_q;
			depth_q <= (cfg_depth_q > LVL_W'(DEPTH_LIMIT)) ? LVL_W'(DEPTH_LIMIT) : cfg_depth_q;
			lvl_q   <= '0;
			node_q  <= '0;
		end else if (advance) begin
			cx_q   <= oct[0] ? cx_q + q_e : cx_q - q_e;
			cy_q   <= oct[1] ? cy_q + q_e : cy_q - q_e;
			cz_q   <= oct[2] ? cz_q + q_e : cz_q - q_e;
			half_q <= q;
			lvl_q  <= lvl_q + LVL_W'(1);
			node_q <= next_node;
		end
		if (capture) begin
			res_status_q <= res_status_d;
			res_occ_q    <= res_occ_d;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_occ_q    <= res_occ_q;
		end
	end

endmodule

@@ rtl/octree_occupancy_map_unit.sv @@
`timescale 1ns / 1ps
// Octree occupancy map unit: top level joining controller, datapath and channels.
// A result follows its item transfer through the bounds test and a descent of D levels, D
// being the configured depth capped at 16, as the descent reads one node row per level; a
// query at a missing child or an insert into a full pool ends sooner, an outside point
// skips the descent. A new item can be taken in the cycle after each result loads; after
// reset a pass zeroes the 4096 rows. Uses oom_pkg, oom_if, oom_ram, oom_ctrl and oom_dp.
module octree_occupancy_map_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [oom_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oom_pkg::CFG_DATA_W-1:0] cfg_data,
	oom_item_if.sink                       item_in,
	oom_result_if.source                   result_out
);
	import oom_pkg::*;

	item_t item;
	cmd_t  cmd;
	stat_t stat;

	assign item.operation     = item_in.operation;
	assign item.point_x       = item_in.point_x;
	assign item.point_y       = item_in.point_y;
	assign item.point_z       = item_in.point_z;
	assign item.mark_occupied = item_in.mark_occupied;

	oom_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (item_in.ready),
		.out_valid(result_out.valid),
		.out_ready(result_out.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	oom_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.out_status   (result_out.status),
		.out_occupancy(result_out.occupancy)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_in.valid && item_in.ready |=> !item_in.ready)
		else $error("A second item was taken while one was in flight.");

	a_outside_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.status == STAT_OUTSIDE |->
		result_out.occupancy == OCC_UNKNOWN)
		else $error("An outside result carries an occupancy.");

	a_full_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid && result_out.status == STAT_FULL |->
		result_out.occupancy == OCC_UNKNOWN)
		else $error("A pool-full result carries an occupancy.");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		stat.alloc |-> !stat.full)
		else $error("A node was allocated from a full pool.");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the octree occupancy map unit: point inserts and queries are checked against
// an octree mirror kept in the bench, under several cube and depth settings.
// Depends on oom_pkg, oom_if and octree_occupancy_map_unit.
module tb_top;
	import oom_pkg::*;

	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 250;
	localparam int POOL_ITEMS   = 370;
	localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
	localparam longint COORD_MIN = -(longint'(1) <<< (COORD_W - 1));
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	oom_item_if   item_ch ();
	oom_result_if result_ch ();

	octree_occupancy_map_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item_in   (item_ch.sink),
		.result_out(result_ch.source)
	);

	int unsigned               tree_child [NODE_POOL*SLOTS];
	bit [OCC_W-1:0]            tree_state [NODE_POOL];
	int unsigned               tree_used;
	logic signed [COORD_W-1:0] map_cx, map_cy, map_cz;
	logic [HALF_W-1:0]         map_half;
	logic [LVL_W-1:0]          map_depth;

	answer_t pending_answers[$];
	item_t   visited_points[$];
	int      errors;
	int      burst_left;
	bit      offering;
	int      hold_asks;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit in_span(longint p, longint c, longint h);
		return p >= c - h && p <= c + h;
	endfunction

	function automatic answer_t descend_tree(item_t it);
		longint px, py, pz, cx, cy, cz, h, q;
		int unsigned node, child, slot, levels, lvl, k;
		logic [OCT_W-1:0] oct;
		answer_t a;
		a.status = STAT_OK;
		a.occupancy = OCC_UNKNOWN;
		px = longint'($signed(it.point_x));
		py = longint'($signed(it.point_y));
		pz = longint'($signed(it.point_z));
		cx = longint'(map_cx);
		cy = longint'(map_cy);
		cz = longint'(map_cz);
		h = longint'(map_half);
		levels = (map_depth > DEPTH_LIMIT) ? DEPTH_LIMIT : map_depth;
		if (!in_span(px, cx, h) || !in_span(py, cy, h) || !in_span(pz, cz, h)) begin
			a.status = STAT_OUTSIDE;
			return a;
		end
		node = 0;
		for (lvl = 0; lvl < levels; lvl++) begin
			q = h >>> 1;
			oct = {pz > cz, py > cy, px > cx};
			slot = node * SLOTS + oct;
			child = tree_child[slot];
			if (child == 0) begin
				if (it.operation == OP_QUERY) begin
					a.occupancy = tree_state[node];
					return a;
				end
				if (tree_used >= NODE_POOL) begin
					a.status = STAT_FULL;
					return a;
				end
				child = tree_used;
				tree_used++;
				for (k = 0; k < SLOTS; k++)
					tree_child[child * SLOTS + k] = 0;
				tree_state[child] = OCC_UNKNOWN;
				tree_child[slot] = child;
			end
			node = child;
			cx += oct[0] ? q : -q;
			cy += oct[1] ? q : -q;
			cz += oct[2] ? q : -q;
			h = q;
		end
		if (it.operation == OP_INSERT)
			tree_state[node] = it.mark_occupied ? OCC_OCCUPIED : OCC_FREE;
		a.occupancy = tree_state[node];
		return a;
	endfunction

	function automatic item_t mk_point(input logic op, input logic signed [COORD_W-1:0] x, y, z,
			input logic occ);
		item_t it;
		it.operation = op;
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		it.mark_occupied = occ;
		return it;
	endfunction

	function automatic logic signed [COORD_W-1:0] pick_coord(longint c, longint h);
		longint lo, hi, v;
		lo = (c - h < COORD_MIN) ? COORD_MIN : c - h;
		hi = (c + h > COORD_MAX) ? COORD_MAX : c + h;
		case ($urandom_range(0, 31))
			0: v = lo;
			1: v = hi;
			2: v = c;
			3: v = (hi < COORD_MAX) ? hi + 1 : hi;
			4: v = (lo > COORD_MIN) ? lo - 1 : lo;
			default: v = lo + longint'({32'd0, $urandom()}) % (hi - lo + 1);
		endcase
		return v[COORD_W-1:0];
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25 && visited_points.size() > 0) begin
			it = visited_points[$urandom_range(0, visited_points.size() - 1)];
		end else if (pick < 33) begin
			it.point_x = $urandom();
			it.point_y = $urandom();
			it.point_z = $urandom();
		end else begin
			it.point_x = pick_coord(longint'(map_cx), longint'(map_half));
			it.point_y = pick_coord(longint'(map_cy), longint'(map_half));
			it.point_z = pick_coord(longint'(map_cz), longint'(map_half));
		end
		it.operation = $urandom_range(0, 1) ? OP_QUERY : OP_INSERT;
		it.mark_occupied = $urandom_range(0, 1);
		return it;
	endfunction

	task automatic send_item(input item_t it);
		bit taken;
		answer_t ans;
		if (burst_left == 0) begin
			if (offering)
				item_ch.valid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= it.operation;
		item_ch.point_x <= it.point_x;
		item_ch.point_y <= it.point_y;
		item_ch.point_z <= it.point_z;
		item_ch.mark_occupied <= it.mark_occupied;
		offering = 1'b1;
		burst_left--;
		do begin
			@(negedge clk);
			taken = item_ch.ready;
			@(posedge clk);
		end while (!taken);
		ans = descend_tree(it);
		if (it.operation == OP_INSERT && ans.status == STAT_OK) begin
			visited_points.push_back(it);
			if (visited_points.size() > 64)
				void'(visited_points.pop_front());
		end
		pending_answers.push_back(ans);
	endtask

	task automatic wait_idle();
		if (offering)
			item_ch.valid <= 1'b0;
		offering = 1'b0;
		burst_left = 0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CENTER_X:  map_cx = data;
			REG_CENTER_Y:  map_cy = data;
			REG_CENTER_Z:  map_cz = data;
			REG_HALF_SIZE: map_half = data[HALF_W-1:0];
			REG_MAX_DEPTH: map_depth = data[LVL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_map(input logic [CFG_DATA_W-1:0] cx, cy, cz, half, depth);
		wait_idle();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_HALF_SIZE, half);
		write_reg(REG_MAX_DEPTH, depth);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_item(random_item());
	endtask

	task automatic test_directed();
		logic signed [COORD_W-1:0] h;
		h = $signed({2'b00, HALF_RESET});
		send_item(mk_point(OP_QUERY, 0, 0, 0, 1'b0));
		send_item(mk_point(OP_INSERT, 0, 0, 0, 1'b1));
		send_item(mk_point(OP_QUERY, 0, 0, 0, 1'b0));
		send_item(mk_point(OP_INSERT, h, h, h, 1'b0));
		send_item(mk_point(OP_QUERY, h, h, h, 1'b0));
		send_item(mk_point(OP_INSERT, -h, -h, -h, 1'b1));
		send_item(mk_point(OP_QUERY, -h, h, -h, 1'b0));
		send_item(mk_point(OP_INSERT, h + 1, 0, 0, 1'b1));
		send_item(mk_point(OP_QUERY, 0, -h - 1, 0, 1'b0));
		send_item(mk_point(OP_QUERY, 0, 0, h + 1, 1'b1));
		send_item(mk_point(OP_INSERT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
		send_item(mk_point(OP_QUERY, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0));
		send_item(mk_point(OP_INSERT, 0, 0, 0, 1'b0));
		send_item(mk_point(OP_QUERY, 0, 0, 0, 1'b1));
		send_item(mk_point(OP_INSERT, 1, 1, 1, 1'b1));
		send_item(mk_point(OP_QUERY, 1, 1, 1, 1'b0));
		send_item(mk_point(OP_QUERY, 0, 0, 1, 1'b0));
		set_map(0, 0, 0, HALF_RESET, 3);
		send_item(mk_point(OP_INSERT, 0, 0, 0, 1'b1));
		set_map(0, 0, 0, HALF_RESET, DEPTH_RESET);
		send_item(mk_point(OP_QUERY, -1, 0, -1, 1'b0));
		send_item(mk_point(OP_QUERY, 5, 5, 5, 1'b0));
		send_item(mk_point(OP_QUERY, 0, 0, 0, 1'b0));
	endtask

	task automatic test_tiny_cube();
		set_map(0, 0, 0, HALF_RESET, 0);
		send_item(mk_point(OP_QUERY, 0, 0, 0, 1'b0));
		send_item(mk_point(OP_INSERT, 0, 0, 0, 1'b0));
		send_random(15);
		set_map($urandom(), $urandom(), $urandom(), 0, 5);
		send_random(25);
		set_map($urandom(), $urandom(), $urandom(), 1, 16);
		send_random(20);
	endtask

	task automatic test_extremes();
		set_map(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_random(40);
		set_map(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 16);
		send_random(30);
		wait_idle();
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		send_random(20);
	endtask

	task automatic test_random_maps();
		int setting;
		for (setting = 0; setting < 5; setting++) begin
			case (setting)
				0: set_map(0, 0, 0, HALF_RESET, DEPTH_RESET);
				1: set_map($urandom(), $urandom(), $urandom(),
					$urandom_range(1 << 16, 1 << 28), $urandom_range(1, 16));
				2: set_map(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h3FFF_FFFF, 12);
				3: set_map($urandom(), $urandom(), $urandom(),
					$urandom_range(1, 64), 16);
				default: set_map($urandom(), $urandom(), $urandom(),
					$urandom_range(0, 32'h3FFF_FFFF), $urandom_range(17, 31));
			endcase
			send_random(RANDOM_ITEMS);
		end
	endtask

	task automatic test_backpressure();
		set_map(0, 0, 0, HALF_RESET, 6);
		hold_asks++;
		send_random(60);
	endtask

	task automatic test_pool_exhaustion();
		item_t it;
		set_map($urandom(), $urandom(), $urandom(), 32'h3FFF_FFFF, 16);
		repeat (POOL_ITEMS) begin
			it = random_item();
			if ($urandom_range(0, 4) != 0)
				it.operation = OP_INSERT;
			send_item(it);
		end
	endtask

	initial begin
		int mode, mode_left, hold_left, hold_seen, phase;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= $urandom_range(0, 1);
					2: result_ch.ready <= (phase % 5 == 0);
					default: result_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin
		bit in_fire, out_fire;
		answer_t got, want;
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(negedge clk);
			in_fire = item_ch.valid && item_ch.ready;
			out_fire = result_ch.valid && result_ch.ready;
			got.status = result_ch.status;
			got.occupancy = result_ch.occupancy;
			@(posedge clk);
			if (out_fire) begin
				if (pending_answers.size() == 0) begin
					$error("result transfer with nothing expected: status %0d, occupancy %0d",
						got.status, got.occupancy);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (got.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, got.status);
						errors++;
					end
					if (got.occupancy !== want.occupancy) begin
						$error("occupancy mismatch: expected %0d, actual %0d",
							want.occupancy, got.occupancy);
						errors++;
					end
				end
			end
			idle = (in_fire || out_fire) ? 0 : idle + 1;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		errors = 0;
		burst_left = 0;
		offering = 1'b0;
		hold_asks = 0;
		tree_used = 1;
		map_cx = '0;
		map_cy = '0;
		map_cz = '0;
		map_half = HALF_RESET;
		map_depth = DEPTH_RESET;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CENTER_X;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.operation <= OP_INSERT;
		item_ch.point_x <= '0;
		item_ch.point_y <= '0;
		item_ch.point_z <= '0;
		item_ch.mark_occupied <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_tiny_cube();
		test_extremes();
		test_random_maps();
		test_backpressure();
		test_pool_exhaustion();
		wait_idle();
		if (errors == 0 && pending_answers.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/oom_pkg.sv
rtl/oom_if.sv
rtl/oom_ram.sv
rtl/oom_ctrl.sv
rtl/oom_dp.sv
rtl/octree_occupancy_map_unit.sv
test/tb_top.sv
